FILE: src/rrack_pkg.sv
package rrack_pkg;

  localparam int unsigned SEQ_W          = 32;
  localparam int unsigned LEN_W          = 9;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned WINDOW_DEF     = 16;
  localparam int unsigned MAX_LENGTH_DEF = 500;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASSIFY,
    ST_CHECK,
    ST_READ,
    ST_LOOK,
    ST_DELIVER
  } state_e;

  // one slot of the reorder store
  typedef struct packed {
    logic             mark;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             dup;
    logic             last;
  } result_t;

endpackage

FILE: src/rrack_ifs.sv
interface rrack_pkt_if import rrack_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output seq_number, output payload_length, input ready);
  modport sink (input valid, input seq_number, input payload_length, output ready);
endinterface

interface rrack_res_if import rrack_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [SEQ_W-1:0]  seq_field;
  logic [LEN_W-1:0]  length_field;
  logic              duplicate;
  logic              last;

  modport source (output valid, output result_kind, output seq_field, output length_field,
                  output duplicate, output last, input ready);
  modport sink (input valid, input result_kind, input seq_field, input length_field,
                input duplicate, input last, output ready);
endinterface

FILE: src/rrack_ram.sv
module rrack_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rrack_outreg.sv
module rrack_outreg import rrack_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    res_i,
  output logic       free_o,
  rrack_res_if.source res_o
);

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (push_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else begin
      valid_q <= valid_d;
      data_q  <= data_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.result_kind  = data_q.kind;
  assign res_o.seq_field    = data_q.seq;
  assign res_o.length_field = data_q.len;
  assign res_o.duplicate    = data_q.dup;
  assign res_o.last         = data_q.last;

endmodule

FILE: src/rrack_ctrl.sv
module rrack_ctrl import rrack_pkg::*; #(
  parameter int unsigned WINDOW     = WINDOW_DEF,
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrack_pkt_if.sink pkt_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      free_i,
  output logic      push_o,
  output result_t   res_o
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned EW = $bits(entry_t);

  state_e state_q, state_d;

  logic [SEQ_W-1:0] seq_q, ne_q, off;
  logic [LEN_W-1:0] len_q, len_in, cur_len_q;
  logic [SW-1:0]    ns_q, ns_next, slot, slot_q, clr_q;
  logic [SW:0]      slot_sum;
  logic             below, beyond, below_q, beyond_q;
  logic             dup_q, ack0_pend_q, fwd_q, mode_q;
  logic             accept, eff_mark;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd_ent;
  logic [EW-1:0] ram_rdata;

  rrack_ram #(
    .WIDTH(EW),
    .DEPTH(WINDOW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ent   = entry_t'(ram_rdata);
  // a read that met a clear of the same slot returned the stale mark
  assign eff_mark = rd_ent.mark && !fwd_q;

  assign pkt_i.ready = (state_q == ST_IDLE);
  assign accept      = pkt_i.valid && pkt_i.ready;
  assign len_in      = (32'(pkt_i.payload_length) > 32'(MAX_LENGTH)) ?
                       LEN_W'(MAX_LENGTH) : pkt_i.payload_length;

  // window position; off fits in SW bits whenever the packet is in window
  assign below    = seq_q < ne_q;
  assign off      = seq_q - ne_q;
  assign beyond   = !below && (off >= 32'(WINDOW));
  assign slot_sum = {1'b0, ns_q} + {1'b0, off[SW-1:0]};
  assign slot     = (slot_sum >= (SW+1)'(WINDOW)) ?
                    SW'(slot_sum - (SW+1)'(WINDOW)) : slot_sum[SW-1:0];

  // next_expected wraps to zero past all ones, slot restarts with it
  assign ns_next = (ne_q == '1) ? '0 :
                   ((ns_q == SW'(WINDOW - 1)) ? '0 : ns_q + 1'b1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SW'(WINDOW - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!beyond_q) begin
          state_d = ST_READ;
        end else if (push_o) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_LOOK;
      ST_LOOK: begin
        if (ack0_pend_q) begin
          state_d = ST_LOOK;
        end else if (eff_mark) begin
          state_d = ST_DELIVER;
        end else if (!mode_q || push_o) begin
          state_d = ST_IDLE;
        end
      end
      ST_DELIVER: begin
        if (push_o) begin
          state_d = ST_LOOK;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = slot;
    push_o    = 1'b0;
    res_o     = '{kind: KIND_ACK, seq: '0, len: '0, dup: 1'b0, last: 1'b0};
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_CLASSIFY: begin
        ram_re = 1'b1;
      end
      ST_CHECK: begin
        if (beyond_q) begin
          push_o = free_i;
          res_o  = '{kind: KIND_DROP, seq: seq_q, len: '0, dup: 1'b0, last: 1'b1};
        end else if (!below_q && !rd_ent.mark) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = '{mark: 1'b1, len: len_q};
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ns_q;
      end
      ST_LOOK: begin
        if (ack0_pend_q) begin
          push_o = free_i;
          res_o  = '{kind: KIND_ACK, seq: seq_q, len: '0, dup: dup_q, last: !eff_mark};
        end else if (eff_mark) begin
          ram_we    = 1'b1;
          ram_waddr = ns_q;
          ram_re    = 1'b1;
          ram_raddr = ns_next;
        end else if (mode_q) begin
          push_o = free_i;
          res_o  = '{kind: KIND_ACK, seq: ne_q - 1'b1, len: '0, dup: dup_q, last: 1'b1};
        end
      end
      ST_DELIVER: begin
        push_o = free_i;
        res_o  = '{kind: KIND_DELIVER, seq: ne_q, len: cur_len_q, dup: dup_q,
                   last: !mode_q && !eff_mark};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      seq_q       <= '0;
      len_q       <= '0;
      ne_q        <= '0;
      ns_q        <= '0;
      slot_q      <= '0;
      below_q     <= 1'b0;
      beyond_q    <= 1'b0;
      dup_q       <= 1'b0;
      ack0_pend_q <= 1'b0;
      fwd_q       <= 1'b0;
      cur_len_q   <= '0;
      mode_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        seq_q <= pkt_i.seq_number;
        len_q <= len_in;
      end
      if (state_q == ST_CLASSIFY) begin
        below_q  <= below;
        beyond_q <= beyond;
        slot_q   <= slot;
        fwd_q    <= 1'b0;
      end
      if (state_q == ST_CHECK) begin
        dup_q       <= below_q || rd_ent.mark;
        ack0_pend_q <= !mode_q;
      end
      if (state_q == ST_READ) begin
        fwd_q <= 1'b0;
      end
      if (state_q == ST_LOOK) begin
        if (ack0_pend_q) begin
          if (push_o) begin
            ack0_pend_q <= 1'b0;
          end
        end else if (eff_mark) begin
          cur_len_q <= rd_ent.len;
          fwd_q     <= (ns_next == ns_q);
        end
      end
      if (state_q == ST_DELIVER && push_o) begin
        ne_q <= ne_q + 1'b1;
        ns_q <= ns_next;
      end
    end
  end

  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.kind == KIND_DROP) |-> (!res_o.dup && res_o.last))
    else $error("drop result with duplicate flag or not last");

  a_drop_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.kind == KIND_DROP) |=> (state_q == ST_IDLE))
    else $error("drop did not end the item");

  a_ne_moves_on_delivery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && res_o.kind == KIND_DELIVER) |=> $stable(ne_q))
    else $error("next expected changed without a delivery");

  a_same_slot_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re && ram_waddr == ram_raddr) |=> fwd_q)
    else $error("same-slot read and write not forwarded");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !accept)
    else $error("packet taken while an item is in work");

endmodule

FILE: src/reorder_receiver_with_ack.sv
// Flow: after the header transfer an item passes CLASSIFY and CHECK, where a drop is pushed;
//   else READ and LOOK, where a per-packet ack is pushed; each push waits while the output is full.
// Throughput: one header at a time; no new header is taken until the item is done, and each
//   released packet needs a slot store read, then clear and push.
// Reset: asynchronous, active low; next expected number and ack mode clear, then a
//   sweep over all WINDOW slots clears the slot store while no header is taken.
module reorder_receiver_with_ack import rrack_pkg::*; #(
  parameter int unsigned WINDOW     = WINDOW_DEF,
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrack_pkt_if.sink   pkt_i,
  rrack_res_if.source res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic    free, push;
  result_t res;

  rrack_ctrl #(
    .WINDOW    (WINDOW),
    .MAX_LENGTH(MAX_LENGTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .free_i     (free),
    .push_o     (push),
    .res_o      (res)
  );

  rrack_outreg u_outreg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .res_i (res),
    .free_o(free),
    .res_o (res_o)
  );

endmodule

FILE: tb/sv/reorder_receiver_with_ack_tb.sv
module reorder_receiver_with_ack_tb;
  import rrack_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_TOP = 2**LEN_W - 1;
  localparam int unsigned LONG_STALL = 150;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  typedef enum int {
    NZ_BELOW,
    NZ_BEYOND,
    NZ_ANY,
    NZ_REPEAT
  } noise_e;

  // Tracks the receive window and holds the results still owed by the block.
  class reorder_tracker;
    logic [SEQ_W-1:0] next_exp;
    bit               marks[WINDOW_DEF];
    logic [LEN_W-1:0] lens[WINDOW_DEF];
    bit               ack_mode;
    result_t          owed[$];
    int               errors;
    int               n_pkts, n_results, n_deliver, n_drop, n_dup;

    function new();
      next_exp = '0;
      ack_mode = 1'b0;
      foreach (marks[i]) marks[i] = 1'b0;
      errors = 0;
      n_pkts = 0;
      n_results = 0;
      n_deliver = 0;
      n_drop = 0;
      n_dup = 0;
    endfunction

    function void set_mode(bit m);
      ack_mode = m;
    endfunction

    function void push(kind_e k, logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l, logic d);
      result_t r;
      r.kind = k;
      r.seq  = s;
      r.len  = l;
      r.dup  = d;
      r.last = 1'b0;
      owed.push_back(r);
    endfunction

    function void take_packet(logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l);
      logic [LEN_W-1:0] l_sat;
      logic [SEQ_W-1:0] offset;
      int unsigned      slot;
      logic             dup;
      l_sat = (l > MAX_LENGTH_DEF) ? LEN_W'(MAX_LENGTH_DEF) : l;
      dup = 1'b0;
      n_pkts++;
      offset = s - next_exp;
      if (s < next_exp) begin
        dup = 1'b1;
      end else if (offset >= WINDOW_DEF) begin
        push(KIND_DROP, s, '0, 1'b0);
        owed[owed.size()-1].last = 1'b1;
        n_drop++;
        return;
      end else begin
        slot = s % WINDOW_DEF;
        if (marks[slot]) begin
          dup = 1'b1;
        end else begin
          marks[slot] = 1'b1;
          lens[slot]  = l_sat;
        end
      end
      if (dup) n_dup++;
      if (!ack_mode) push(KIND_ACK, s, '0, dup);
      for (int g = 0; g < WINDOW_DEF; g++) begin
        slot = next_exp % WINDOW_DEF;
        if (!marks[slot]) break;
        marks[slot] = 1'b0;
        push(KIND_DELIVER, next_exp, lens[slot], dup);
        n_deliver++;
        next_exp = next_exp + 1;
      end
      if (ack_mode) push(KIND_ACK, next_exp - 1, '0, dup);
      owed[owed.size()-1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [SEQ_W-1:0] e, logic [SEQ_W-1:0] a);
      if (a !== e) begin
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      n_results++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: kind %0d seq %0h len %0d", $time,
                 got.kind, got.seq, got.len);
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("result_kind", SEQ_W'(e.kind), SEQ_W'(got.kind));
      cmp("seq_field", e.seq, got.seq);
      cmp("length_field", SEQ_W'(e.len), SEQ_W'(got.len));
      cmp("duplicate", SEQ_W'(e.dup), SEQ_W'(got.dup));
      cmp("last", SEQ_W'(e.last), SEQ_W'(got.last));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  rrack_pkt_if pkt ();
  rrack_res_if res ();

  reorder_tracker tracker;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_left = 0;
  bit          long_stall_req = 1'b0;
  bit          long_stall_done = 1'b0;

  reorder_receiver_with_ack i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: random backpressure, one long hold-off on request
  always @(posedge clk_i) begin
    result_t got;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got.kind = kind_e'(res.result_kind);
        got.seq  = res.seq_field;
        got.len  = res.length_field;
        got.dup  = res.duplicate;
        got.last = res.last;
        tracker.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res.ready <= 1'b0;
      end else if (long_stall_req && !long_stall_done) begin
        stall_left <= LONG_STALL;
        long_stall_done <= 1'b1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // offers one header; returns at the edge of its transfer with valid still high
  task automatic send_pkt(logic [SEQ_W-1:0] s, logic [LEN_W-1:0] l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      pkt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt.valid          <= 1'b1;
    pkt.seq_number     <= s;
    pkt.payload_length <= l;
    do @(posedge clk_i); while (!pkt.ready);
    tracker.take_packet(s, l);
  endtask

  task automatic wait_drain();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tracker.set_mode(m);
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(MAX_LENGTH_DEF + 1, LEN_TOP));
    return LEN_W'($urandom_range(0, MAX_LENGTH_DEF));
  endfunction

  // mostly shuffled runs from the expected number upward, with losses and noise mixed in
  task automatic run_phase(int unsigned n_items);
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seqs[WINDOW_DEF];
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] s;
    int unsigned      k, j, span, sent, n_send;
    noise_e           nz;
    sent = 0;
    while (sent < n_items) begin
      base = tracker.next_exp;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, WINDOW_DEF) : $urandom_range(1, 6);
      for (int i = 0; i < k; i++) seqs[i] = base + i;
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = seqs[i];
        seqs[i] = seqs[j];
        seqs[j] = tmp;
      end
      // a lost packet holds the window back until a later run resends it
      n_send = (k > 1 && $urandom_range(0, 3) == 0) ? k - 1 : k;
      for (int i = 0; i < n_send; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          nz = noise_e'($urandom_range(NZ_BELOW, NZ_REPEAT));
          case (nz)
            NZ_BELOW: begin
              span = (base > 20) ? 20 : base;
              s = (span == 0) ? $urandom() : base - $urandom_range(1, span);
            end
            NZ_BEYOND: s = base + $urandom_range(WINDOW_DEF, 4 * WINDOW_DEF);
            NZ_ANY:    s = $urandom();
            default:   s = seqs[$urandom_range(0, k - 1)];
          endcase
          send_pkt(s, rand_len());
          sent++;
        end
        send_pkt(seqs[i], rand_len());
        sent++;
      end
    end
    pkt.valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    pkt.valid          <= 1'b0;
    pkt.seq_number     <= '0;
    pkt.payload_length <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cumulative acks: all ones before the first delivery, duplicates, drops
    write_mode(1'b1);
    rx_idle_pct = 30;
    send_pkt(32'd2, 9'd500);
    send_pkt(32'd2, 9'd7);
    send_pkt(32'd0, 9'd0);
    send_pkt(32'd1, 9'(LEN_TOP));
    send_pkt(32'd0, 9'd11);
    send_pkt(32'hFFFF_FFFF, 9'd1);
    send_pkt(32'd19, 9'd3);
    send_pkt(32'd18, 9'd256);
    pkt.valid <= 1'b0;
    wait_drain();

    // per-packet acks: fill the window, then the missing head releases sixteen
    write_mode(1'b0);
    for (int i = 4; i <= 17; i++) send_pkt(SEQ_W'(i), 9'(i * 29));
    send_pkt(32'd3, 9'd499);
    pkt.valid <= 1'b0;
    wait_drain();

    write_mode(1'b1);
    tx_idle_pct = 24;
    rx_idle_pct = 85;
    run_phase(ITEMS_PER_PHASE);
    wait_drain();

    write_mode(1'b0);
    tx_idle_pct = 85;
    rx_idle_pct = 24;
    run_phase(ITEMS_PER_PHASE);
    wait_drain();

    write_mode(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_stall_req = 1'b1;
    run_phase(ITEMS_PER_PHASE);
    wait_drain();

    $display("covered %0d headers and %0d results in both ack modes under stalls",
             tracker.n_pkts, tracker.n_results);
    $display("%0d in-order releases, %0d out-of-window drops, %0d duplicate headers",
             tracker.n_deliver, tracker.n_drop, tracker.n_dup);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/rrack_pkg.sv
src/rrack_ifs.sv
src/rrack_ram.sv
src/rrack_outreg.sv
src/rrack_ctrl.sv
src/reorder_receiver_with_ack.sv
tb/sv/reorder_receiver_with_ack_tb.sv
